>>> hdl/sktab_pkg.sv
// Shared constants and types for the sorted key table.
package sktab_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned KEY_BITS = 32;

  localparam int unsigned KEY_FIELD_W = 32;
  localparam int unsigned POS_FIELD_W = 9;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);

  localparam int unsigned OUT_FIELDS_W = 1 + POS_FIELD_W + STATUS_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic OP_SEARCH = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic capture;
    logic commit;
  } cell_ctrl_t;

endpackage

>>> hdl/sktab_cell.sv
// One table cell: holds a key, compares it and shifts it to its upper neighbour.
module sktab_cell (
  input  logic                              clk_i,
  input  sktab_pkg::cell_ctrl_t             ctrl_i,
  input  logic                              occupied_i,
  input  logic [sktab_pkg::KEY_BITS-1:0]    search_key_i,
  input  logic [sktab_pkg::KEY_BITS-1:0]    new_key_i,
  input  logic [sktab_pkg::KEY_BITS-1:0]    prev_key_i,
  input  logic                              prev_lt_i,
  output logic [sktab_pkg::KEY_BITS-1:0]    key_o,
  output logic                              lt_o,
  output logic                              eq_o
);

  logic [sktab_pkg::KEY_BITS-1:0] key_q, key_d;
  logic                           lt_q, lt_d;
  logic                           eq_q, eq_d;

  always_comb begin
    lt_d  = lt_q;
    eq_d  = eq_q;
    key_d = key_q;
    if (ctrl_i.capture) begin
      lt_d = occupied_i && (key_q < search_key_i);
      eq_d = occupied_i && (key_q == search_key_i);
    end
    // keep smaller keys, place the new key at the boundary, shift the rest up
    if (ctrl_i.commit && !lt_q) begin
      if (prev_lt_i) begin
        key_d = new_key_i;
      end else begin
        key_d = prev_key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lt_q  <= lt_d;
    eq_q  <= eq_d;
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

>>> hdl/sktab_enc.sv
// Turns the per-cell compare flags into the sorted rank and the hit flag.
module sktab_enc (
  input  logic [sktab_pkg::CAPACITY-1:0] lt_i,
  input  logic [sktab_pkg::CAPACITY-1:0] eq_i,
  output logic [sktab_pkg::CNT_W-1:0]    rank_o,
  output logic                           hit_o
);

  logic [sktab_pkg::CAPACITY:0] bound;

  always_comb begin
    bound[0] = !lt_i[0];
    for (int unsigned i = 1; i < sktab_pkg::CAPACITY; i++) begin
      bound[i] = lt_i[i-1] && !lt_i[i];
    end
    bound[sktab_pkg::CAPACITY] = lt_i[sktab_pkg::CAPACITY-1];
  end

  always_comb begin
    rank_o = '0;
    for (int unsigned i = 0; i <= sktab_pkg::CAPACITY; i++) begin
      rank_o = rank_o | (bound[i] ? sktab_pkg::CNT_W'(i) : '0);
    end
  end

  assign hit_o = |eq_i;

endmodule

>>> hdl/sorted_key_table.sv
// Sorted key table top level: stream ports, cell row, rank encoder, result register.
// A result is registered once its transaction is accepted and the output register is free or read.
// The cells compare in the accept cycle and shift or hold when that result is registered; a new
// transaction is taken only after that, so the following compare must see the updated row.
// The output register holds a result while the next transaction is taken.
// Reset clears the entry count and the handshake state; cell keys are not reset.
module sorted_key_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] key
  input  logic [sktab_pkg::KEY_FIELD_W-1:0]  s_axis_tdata_i,
  // [0] opcode
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] found, [9:1] position, [11:10] status, [15:12] zero
  output logic [sktab_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned CAP = sktab_pkg::CAPACITY;
  localparam int unsigned KB  = sktab_pkg::KEY_BITS;
  localparam int unsigned CW  = sktab_pkg::CNT_W;
  localparam int unsigned PW  = sktab_pkg::POS_FIELD_W;

  logic                          pend_q;
  logic                          op_q;
  logic [KB-1:0]                 key_q;
  logic [CW-1:0]                 count_q, count_d;
  logic                          m_valid_q;
  logic [sktab_pkg::OUT_DATA_W-1:0] m_data_q;

  logic                          accept;
  logic                          fire;
  logic                          full;
  logic                          do_insert;
  logic [KB-1:0]                 in_key;
  logic [KB+sktab_pkg::KEY_FIELD_W-1:0] in_key_ext;
  logic [CW+PW-1:0]              rank_ext;
  logic [CW-1:0]                 rank;
  logic                          hit;
  logic [sktab_pkg::STATUS_W-1:0] status;
  sktab_pkg::cell_ctrl_t         ctrl;

  logic [CAP-1:0]                lt;
  logic [CAP-1:0]                eq;
  logic [KB-1:0]                 cell_key [CAP];

  assign in_key_ext = {{KB{1'b0}}, s_axis_tdata_i};
  assign in_key     = in_key_ext[KB-1:0];

  assign s_axis_tready_o = !pend_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign fire            = pend_q && (!m_valid_q || m_axis_tready_i);
  assign full            = (count_q == CW'(CAP));
  assign do_insert       = fire && (op_q == sktab_pkg::OP_INSERT) && !hit && !full;

  assign ctrl.capture = accept;
  assign ctrl.commit  = do_insert;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [KB-1:0] prev_key;
    logic          prev_lt;
    if (i == 0) begin : g_first
      assign prev_key = key_q;
      assign prev_lt  = 1'b1;
    end else begin : g_rest
      assign prev_key = cell_key[i-1];
      assign prev_lt  = lt[i-1];
    end
    sktab_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (CW'(i) < count_q),
      .search_key_i(in_key),
      .new_key_i   (key_q),
      .prev_key_i  (prev_key),
      .prev_lt_i   (prev_lt),
      .key_o       (cell_key[i]),
      .lt_o        (lt[i]),
      .eq_o        (eq[i])
    );
  end

  sktab_enc u_enc (
    .lt_i  (lt),
    .eq_i  (eq),
    .rank_o(rank),
    .hit_o (hit)
  );

  assign rank_ext = {{PW{1'b0}}, rank};

  always_comb begin
    status = sktab_pkg::STATUS_OK;
    if (op_q == sktab_pkg::OP_INSERT) begin
      if (hit) begin
        status = sktab_pkg::STATUS_DUP;
      end else if (full) begin
        status = sktab_pkg::STATUS_FULL;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
      count_q   <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        pend_q <= 1'b1;
      end else if (fire) begin
        pend_q <= 1'b0;
      end
      if (fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tuser_i;
      key_q <= in_key;
    end
    if (fire) begin
      m_data_q <= sktab_pkg::OUT_DATA_W'({status, rank_ext[PW-1:0], hit});
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

>>> tb/sorted_key_table_tb.sv
// Self-checking testbench for the sorted key table: directed and random search/insert traffic.
module sorted_key_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LONG_HOLD      = 80;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_LIMIT    = 2000;
  localparam logic [sktab_pkg::KEY_FIELD_W-1:0] KEY_TOP = '1;

  typedef struct packed {
    logic                              found;
    logic [sktab_pkg::POS_FIELD_W-1:0] position;
    logic [sktab_pkg::STATUS_W-1:0]    status;
  } table_result_t;

  logic                              clk_i;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  logic [sktab_pkg::KEY_FIELD_W-1:0] s_axis_tdata_i = '0;
  logic                              s_axis_tuser_i = sktab_pkg::OP_SEARCH;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  logic [sktab_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o;

  logic [sktab_pkg::KEY_FIELD_W-1:0] stored_keys[$];
  table_result_t          pending_results[$];
  table_result_t          want;
  int unsigned            error_count = 0;
  int unsigned            quiet_cycles = 0;
  bit                     idle_on = 1'b0;
  int unsigned            hold_requests = 0;
  int unsigned            hold_served = 0;
  int unsigned            hold_left = 0;
  int unsigned            stall_left = 0;

  sorted_key_table u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Rank lookup on the shadow table, then insert when allowed.
  function automatic table_result_t table_apply(input logic op,
                                                input logic [sktab_pkg::KEY_FIELD_W-1:0] key);
    table_result_t r;
    int unsigned   pos;
    logic          hit;
    pos = 0;
    while (pos < stored_keys.size() && stored_keys[pos] < key) pos++;
    hit = (pos < stored_keys.size()) && (stored_keys[pos] == key);
    r.found    = hit;
    r.position = pos[sktab_pkg::POS_FIELD_W-1:0];
    r.status   = sktab_pkg::STATUS_OK;
    if (op == sktab_pkg::OP_INSERT) begin
      if (hit) begin
        r.status = sktab_pkg::STATUS_DUP;
      end else if (stored_keys.size() >= sktab_pkg::CAPACITY) begin
        r.status = sktab_pkg::STATUS_FULL;
      end else begin
        stored_keys.insert(pos, key);
      end
    end
    return r;
  endfunction

  // Mix of fresh keys, stored keys and their neighbours.
  function automatic logic [sktab_pkg::KEY_FIELD_W-1:0] pick_key();
    logic [sktab_pkg::KEY_FIELD_W-1:0] k;
    int unsigned                       sel;
    sel = $urandom_range(0, 7);
    if (stored_keys.size() == 0 || sel < 4) begin
      k = $urandom();
    end else begin
      k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      if (sel == 5) k = k + 1;
      else if (sel == 6) k = k - 1;
    end
    return k;
  endfunction

  task automatic send_item(input logic op, input logic [sktab_pkg::KEY_FIELD_W-1:0] key);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= key;
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(table_apply(op, key));
  endtask

  // Keep the top key out of the table until it is full.
  task automatic send_random(input logic op);
    logic [sktab_pkg::KEY_FIELD_W-1:0] key;
    key = pick_key();
    if (op == sktab_pkg::OP_INSERT && key == KEY_TOP) key = KEY_TOP - 1;
    send_item(op, key);
  endtask

  task automatic test_empty_table();
    send_item(sktab_pkg::OP_SEARCH, '0);
    send_item(sktab_pkg::OP_SEARCH, KEY_TOP);
    send_item(sktab_pkg::OP_SEARCH, 32'h5555_5555);
  endtask

  task automatic test_directed_ops();
    send_item(sktab_pkg::OP_INSERT, 32'h8000_0000);
    send_item(sktab_pkg::OP_INSERT, 32'h0000_0000);
    send_item(sktab_pkg::OP_INSERT, 32'h8000_0000);
    send_item(sktab_pkg::OP_SEARCH, 32'h0000_0000);
    send_item(sktab_pkg::OP_SEARCH, 32'h8000_0000);
    send_item(sktab_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    send_item(sktab_pkg::OP_SEARCH, KEY_TOP);
    send_item(sktab_pkg::OP_INSERT, 32'h7FFF_FFFF);
    send_item(sktab_pkg::OP_INSERT, 32'h0000_0001);
    send_item(sktab_pkg::OP_INSERT, 32'hFFFF_FFFE);
    send_item(sktab_pkg::OP_INSERT, 32'hAAAA_AAAA);
    send_item(sktab_pkg::OP_INSERT, 32'h5555_5555);
    send_item(sktab_pkg::OP_SEARCH, 32'h5555_5555);
    send_item(sktab_pkg::OP_SEARCH, 32'hFFFF_FFFE);
    send_item(sktab_pkg::OP_SEARCH, KEY_TOP);
    send_item(sktab_pkg::OP_INSERT, 32'h0000_0000);
    send_item(sktab_pkg::OP_INSERT, 32'hFFFF_FFFE);
    send_item(sktab_pkg::OP_SEARCH, 32'h0000_0002);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    idle_on = 1'b1;
    repeat (count) begin
      send_random(($urandom_range(0, 4) < 3) ? sktab_pkg::OP_INSERT : sktab_pkg::OP_SEARCH);
    end
  endtask

  task automatic test_backpressure();
    hold_requests++;
    repeat (12) begin
      send_random(($urandom_range(0, 1) == 0) ? sktab_pkg::OP_INSERT : sktab_pkg::OP_SEARCH);
    end
  endtask

  task automatic test_fill_to_capacity();
    while (stored_keys.size() < sktab_pkg::CAPACITY) send_random(sktab_pkg::OP_INSERT);
  endtask

  task automatic test_full_table();
    idle_on = 1'b0;
    send_item(sktab_pkg::OP_INSERT, KEY_TOP);
    send_item(sktab_pkg::OP_SEARCH, KEY_TOP);
    send_item(sktab_pkg::OP_INSERT, stored_keys[0]);
    send_item(sktab_pkg::OP_INSERT, stored_keys[sktab_pkg::CAPACITY - 1]);
    send_item(sktab_pkg::OP_SEARCH, stored_keys[sktab_pkg::CAPACITY / 2]);
    send_item(sktab_pkg::OP_SEARCH, 32'h0000_0000);
    repeat (30) begin
      send_random(($urandom_range(0, 1) == 0) ? sktab_pkg::OP_INSERT : sktab_pkg::OP_SEARCH);
    end
  endtask

  // Drive the receiver side: long hold on request, otherwise random stall bursts while idle_on is set.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served     <= hold_served + 1;
      hold_left       <= LONG_HOLD - 1;
      m_axis_tready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left      <= $urandom_range(0, 16);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: tdata %h", m_axis_tdata_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[0] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, m_axis_tdata_o[0]);
          error_count++;
        end
        if (m_axis_tdata_o[9:1] !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, m_axis_tdata_o[9:1]);
          error_count++;
        end
        if (m_axis_tdata_o[11:10] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata_o[11:10]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sorted_key_table_tb: errors");
      $finish;
    end
  end

  initial begin
    int unsigned waited;
    waited = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_directed_ops();
    test_random_traffic(440);
    test_backpressure();
    test_fill_to_capacity();
    test_full_table();
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("sorted_key_table_tb: errors");
    end else begin
      repeat (4) @(posedge clk_i);
      if (error_count == 0) begin
        $display("sorted_key_table_tb: clean");
      end else begin
        $display("sorted_key_table_tb: errors");
      end
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/sktab_pkg.sv
hdl/sktab_cell.sv
hdl/sktab_enc.sv
hdl/sorted_key_table.sv
tb/sorted_key_table_tb.sv
